@@ sv/tdp_pkg.sv @@
package tdp_pkg;

    // Default width of the number that is tested.
    localparam int NUM_WIDTH_DEF = 32;

    // Small primes that are tested by direct compare and then as divisors.
    localparam int PRIME_2 = 2;
    localparam int PRIME_3 = 3;
    localparam int PRIME_5 = 5;
    localparam int PRIME_7 = 7;

    // First divisor at which the square-root bound applies.
    localparam int FIRST_TRIAL = 11;

    // Divisor steps: 2 -> 3, 7 -> 11, otherwise to the next odd number.
    localparam int STEP_AFTER_TWO   = 1;
    localparam int STEP_AFTER_SEVEN = 4;
    localparam int STEP_ODD         = 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_RUN,
        S_DONE
    } t_state;

endpackage

@@ sv/tdp_div.sv @@
module tdp_div #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [NUM_WIDTH-1:0] i_div,
    output logic                 o_done,
    output logic [NUM_WIDTH-1:0] o_quo,
    output logic [NUM_WIDTH-1:0] o_rem
);
    import tdp_pkg::*;

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic [CNT_W-1:0]     r_cnt;
    logic                 r_done;
    logic [NUM_WIDTH-1:0] r_quo;
    logic [NUM_WIDTH-1:0] r_rem;
    logic [NUM_WIDTH-1:0] r_d;

    logic [NUM_WIDTH:0]   trial;
    logic [NUM_WIDTH:0]   diff;
    logic                 fits;
    logic                 busy;

    // One restoring step per cycle: bring down the next dividend bit and
    // subtract the divisor when it fits.
    assign busy  = (r_cnt != '0);
    assign trial = {r_rem, r_quo[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, r_d};
    assign fits  = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_WIDTH);
            end else if (busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_d   <= i_div;
        end else if (busy) begin
            r_quo <= {r_quo[NUM_WIDTH-2:0], fits};
            r_rem <= fits ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    // A new division is only started once the previous one has finished.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !busy)
        else $error("divider started while busy");

    // Completion is a single-cycle pulse that follows the last step.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("divider done held longer than one cycle");

    a_done_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(r_cnt == CNT_W'(1)))
        else $error("divider done without a final step");

endmodule

@@ sv/trial_division_prime_test.sv @@
// Trial-division primality tester.
//
// Input channel: i_valid / o_stall carry one 32-bit word, i_candidate. A word
// is taken at a rising edge where i_valid is high and o_stall is low. The
// candidate is cut or zero-extended to NUM_WIDTH bits before it is tested.
// Output channel: o_valid / i_stall carry one word, o_is_prime, for each
// input word, in order.
//
// Candidates 0, 1, 2, 3, 5 and 7 are decided at acceptance without the divider.
// Other candidates are divided by 2, 3, 5, 7 and then 11, 13, 15, ... while
// the divisor does not exceed the quotient. Each trial runs in the shared
// bit-serial divider, so a 32-bit prime near 2^32 takes about 32770 trials;
// the divider sets the rate.
// One candidate is worked on at a time; o_stall is high from acceptance until
// the result has been moved into the output register.
//
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register. While the receiver stalls, the result word stays in
// the output register; a new candidate can be taken and tested meanwhile, and
// its result waits until the output register frees up.
module trial_division_prime_test #(
    parameter int NUM_WIDTH = tdp_pkg::NUM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_candidate,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_prime
);
    import tdp_pkg::*;

    t_state               r_state;
    t_state               n_state;

    logic [NUM_WIDTH-1:0] r_num;
    logic [NUM_WIDTH-1:0] r_div;
    logic                 r_result;
    logic                 r_out_valid;
    logic                 r_out_prime;

    logic [NUM_WIDTH-1:0] cand;
    logic                 in_take;
    logic                 cand_small_prime;
    logic                 cand_below_two;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_WIDTH-1:0] div_quo;
    logic [NUM_WIDTH-1:0] div_rem;
    logic                 past_bound;
    logic                 exact;
    logic                 out_load;
    logic [NUM_WIDTH-1:0] next_div;

    // The candidate is cut or zero-extended to the working width.
    assign cand = NUM_WIDTH'(i_candidate);

    assign cand_small_prime = (cand == NUM_WIDTH'(PRIME_2)) || (cand == NUM_WIDTH'(PRIME_3)) ||
                              (cand == NUM_WIDTH'(PRIME_5)) || (cand == NUM_WIDTH'(PRIME_7));
    assign cand_below_two   = (cand < NUM_WIDTH'(PRIME_2));

    // The square-root bound only applies from divisor FIRST_TRIAL (11) on;
    // the small primes before it are plain divisibility checks. Comparing the
    // divisor with the quotient avoids squaring it.
    assign past_bound = (r_div >= NUM_WIDTH'(FIRST_TRIAL)) && (r_div > div_quo);
    assign exact      = (div_rem == '0);

    always_comb begin
        if (r_div == NUM_WIDTH'(PRIME_2)) begin
            next_div = r_div + NUM_WIDTH'(STEP_AFTER_TWO);
        end else if (r_div == NUM_WIDTH'(PRIME_7)) begin
            next_div = r_div + NUM_WIDTH'(STEP_AFTER_SEVEN);
        end else begin
            next_div = r_div + NUM_WIDTH'(STEP_ODD);
        end
    end

    // Output decode of the sequencer.
    always_comb begin
        o_stall   = (r_state != S_IDLE);
        div_start = (r_state == S_START);
        out_load  = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    end

    assign in_take = i_valid && !o_stall;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (cand_small_prime || cand_below_two) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (div_done) begin
                    if (past_bound || exact) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current candidate and the result word.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_num    <= cand;
            r_div    <= NUM_WIDTH'(PRIME_2);
            r_result <= cand_small_prime;
        end else if ((r_state == S_RUN) && div_done) begin
            if (past_bound) begin
                r_result <= 1'b1;
            end else if (exact) begin
                r_result <= 1'b0;
            end else begin
                r_div <= next_div;
            end
        end
        if (out_load) begin
            r_out_prime <= r_result;
        end
    end

    tdp_div #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_div   (r_div),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out_prime;

    // An accepted word always starts work on the next cycle.
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_START) || (r_state == S_DONE))
        else $error("accepted word did not start a test");

    // A finished result is not dropped while the receiver stalls.
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && i_stall |=> r_state == S_DONE)
        else $error("result left the sequencer while output was full");

    // Beyond the first prime every trial divisor is odd.
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) && (r_div != NUM_WIDTH'(PRIME_2)) |-> r_div[0])
        else $error("even trial divisor");

    // The divider only reports completion while a trial is pending.
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_RUN)
        else $error("divider finished outside of a trial");

endmodule
